// ----- src/c6cc_pkg.sv -----
// ----------------------------------------------------------------------------
// c6cc_pkg - shared types and constants for the cycle count core of the 6502
// Opcode codes, opcode field groups, base-count tables and the transaction
// types passed between the pipeline and the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package c6cc_pkg;

   // Opcodes handled ahead of the table lookup
   localparam logic [7:0] OP_BRK      = 8'h00;
   localparam logic [7:0] OP_JSR      = 8'h20;
   localparam logic [7:0] OP_RTI      = 8'h40;
   localparam logic [7:0] OP_RTS      = 8'h60;
   localparam logic [7:0] OP_PHP      = 8'h08;
   localparam logic [7:0] OP_PLP      = 8'h28;
   localparam logic [7:0] OP_PHA      = 8'h48;
   localparam logic [7:0] OP_PLA      = 8'h68;
   localparam logic [7:0] OP_NOP_ZP0  = 8'h04;
   localparam logic [7:0] OP_NOP_ZP1  = 8'h44;
   localparam logic [7:0] OP_NOP_ZP2  = 8'h64;
   localparam logic [7:0] OP_NOP_ABS  = 8'h0C;
   localparam logic [7:0] OP_NOP_ZPX0 = 8'h14;
   localparam logic [7:0] OP_NOP_ZPX1 = 8'h34;
   localparam logic [7:0] OP_NOP_ZPX2 = 8'h54;
   localparam logic [7:0] OP_NOP_ZPX3 = 8'h74;
   localparam logic [7:0] OP_NOP_ZPX4 = 8'hD4;
   localparam logic [7:0] OP_NOP_ZPX5 = 8'hF4;

   // Low-nibble and branch patterns
   localparam logic [3:0] LO_STACK    = 4'h8;
   localparam logic [3:0] LO_TRANSFER = 4'hA;
   localparam logic [3:0] HI_TRANSFER = 4'h8;
   localparam logic [4:0] BRANCH_PAT  = 5'b10000;

   // cc groups
   localparam logic [1:0] CC_CTL = 2'd0;
   localparam logic [1:0] CC_ALU = 2'd1;
   localparam logic [1:0] CC_RMW = 2'd2;

   // aaa codes
   localparam logic [2:0] AAA_0 = 3'd0;
   localparam logic [2:0] AAA_2 = 3'd2;
   localparam logic [2:0] AAA_3 = 3'd3;
   localparam logic [2:0] AAA_STORE = 3'd4;
   localparam logic [2:0] AAA_LOAD  = 3'd5;
   localparam logic [2:0] AAA_INC   = 3'd6;

   // bbb codes
   localparam logic [2:0] BBB_INDY = 3'd4;
   localparam logic [2:0] BBB_ABSY = 3'd6;
   localparam logic [2:0] BBB_ABSX = 3'd7;

   // Branch flag selectors
   localparam logic [1:0] BR_N = 2'd0;
   localparam logic [1:0] BR_V = 2'd1;
   localparam logic [1:0] BR_C = 2'd2;
   localparam logic [1:0] BR_Z = 2'd3;

   // Table entry: bit 3 marks undefined, bits 2:0 the base count.
   // An undefined entry carries count 2 so it reads out directly.
   localparam logic [3:0] TB_U = 4'b1010;

   localparam logic [7:0][3:0] TAB_ALU    = {4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd2, 4'd3, 4'd6};
   localparam logic [7:0][3:0] TAB_STA    = {4'd5, 4'd5, 4'd4, 4'd6, 4'd4, TB_U, 4'd3, 4'd6};
   localparam logic [7:0][3:0] TAB_RMW    = {4'd7, TB_U, 4'd6, TB_U, 4'd6, 4'd2, 4'd5, TB_U};
   localparam logic [7:0][3:0] TAB_STX    = {TB_U, TB_U, 4'd4, TB_U, 4'd4, TB_U, 4'd3, TB_U};
   localparam logic [7:0][3:0] TAB_LDX    = {4'd4, TB_U, 4'd4, TB_U, 4'd4, TB_U, 4'd3, 4'd2};
   localparam logic [7:0][3:0] TAB_INCDEC = {4'd7, TB_U, 4'd6, TB_U, 4'd6, TB_U, 4'd5, TB_U};
   localparam logic [7:0][3:0] TAB_CTL    = {4'd4, TB_U, 4'd4, TB_U, 4'd4, TB_U, 4'd3, 4'd2};

   // Only the low bytes of the address words matter for page crossing
   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] operand_lo;
      logic [7:0] pointer_lo;
      logic [7:0] pc_lo;
      logic [7:0] index_x;
      logic [7:0] index_y;
      logic [7:0] status;
   } item_type;

   typedef struct packed {
      logic [2:0] cycles;
      logic       undefined_op;
   } result_type;

endpackage

`default_nettype wire

// ----- src/c6cc_if.sv -----
// ----------------------------------------------------------------------------
// c6cc_if - valid/ready channels of the cycle count core for the 6502
// Request channel carries one instruction context, response channel carries
// the cycle count.
// ----------------------------------------------------------------------------
`default_nettype none

interface c6cc_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  opcode;
   logic [15:0] operand_word;
   logic [15:0] pointer_word;
   logic [15:0] operand_pc;
   logic [7:0]  index_x;
   logic [7:0]  index_y;
   logic [7:0]  status;

   modport source (
      output valid, opcode, operand_word, pointer_word, operand_pc,
             index_x, index_y, status,
      input  ready
   );
   modport sink (
      input  valid, opcode, operand_word, pointer_word, operand_pc,
             index_x, index_y, status,
      output ready
   );
endinterface

interface c6cc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] cycles;
   logic       undefined_op;

   modport source (output valid, cycles, undefined_op, input ready);
   modport sink   (input valid, cycles, undefined_op, output ready);
endinterface

`default_nettype wire

// ----- src/c6cc_decode.sv -----
// ----------------------------------------------------------------------------
// c6cc_decode - opcode timing decoder
// Looks up the base cycle count from the opcode fields and adds the page
// crossing and taken-branch penalties.
// ----------------------------------------------------------------------------
`default_nettype none

module c6cc_decode (
   input  wire  c6cc_pkg::item_type   item,
   output       c6cc_pkg::result_type result
);

   // Carry out of the low byte means the high byte changed
   function automatic logic low_carry(input logic [7:0] lo, input logic [7:0] idx);
      logic [8:0] sum;
      sum = {1'b0, lo} + {1'b0, idx};
      return sum[8];
   endfunction

   logic [2:0] aaa;
   logic [2:0] bbb;
   logic [1:0] cc;
   logic [7:0] op;

   assign op  = item.opcode;
   assign aaa = op[7:5];
   assign bbb = op[4:2];
   assign cc  = op[1:0];

   always_comb begin
      logic [3:0] entry;
      logic       use_tab;
      logic       pen;
      logic       flag;
      logic [7:0] next_lo;
      logic [8:0] tgt_sum;
      logic [2:0] cyc;

      entry   = 4'd2;
      use_tab = 1'b0;
      pen     = 1'b0;
      flag    = 1'b0;
      cyc     = 3'd2;
      next_lo = item.pc_lo + 8'd1;
      tgt_sum = {1'b0, next_lo} + {1'b0, item.operand_lo};

      priority if (op == c6cc_pkg::OP_NOP_ZP0 || op == c6cc_pkg::OP_NOP_ZP1 ||
                   op == c6cc_pkg::OP_NOP_ZP2) begin
         cyc = 3'd3;
      end else if (op == c6cc_pkg::OP_NOP_ABS || op == c6cc_pkg::OP_NOP_ZPX0 ||
                   op == c6cc_pkg::OP_NOP_ZPX1 || op == c6cc_pkg::OP_NOP_ZPX2 ||
                   op == c6cc_pkg::OP_NOP_ZPX3 || op == c6cc_pkg::OP_NOP_ZPX4 ||
                   op == c6cc_pkg::OP_NOP_ZPX5) begin
         cyc = 3'd4;
      end else if (op[4:0] == c6cc_pkg::BRANCH_PAT) begin
         unique case (op[7:6])
            c6cc_pkg::BR_N: flag = item.status[7];
            c6cc_pkg::BR_V: flag = item.status[6];
            c6cc_pkg::BR_C: flag = item.status[0];
            c6cc_pkg::BR_Z: flag = item.status[1];
            default:        flag = 1'b0;
         endcase
         // Negative offset stays on the page only when the low add carries
         if (flag == op[5]) begin
            cyc = (tgt_sum[8] ^ item.operand_lo[7]) ? 3'd4 : 3'd3;
         end
      end else if (op == c6cc_pkg::OP_BRK) begin
         cyc = item.status[2] ? 3'd2 : 3'd7;
      end else if (op == c6cc_pkg::OP_JSR || op == c6cc_pkg::OP_RTI ||
                   op == c6cc_pkg::OP_RTS) begin
         cyc = 3'd6;
      end else if (op[3:0] == c6cc_pkg::LO_STACK) begin
         if (op == c6cc_pkg::OP_PHP || op == c6cc_pkg::OP_PHA) begin
            cyc = 3'd3;
         end else if (op == c6cc_pkg::OP_PLP || op == c6cc_pkg::OP_PLA) begin
            cyc = 3'd4;
         end else begin
            cyc = 3'd2;
         end
      end else if (op[3:0] == c6cc_pkg::LO_TRANSFER && op[7:4] >= c6cc_pkg::HI_TRANSFER) begin
         cyc = 3'd2;
      end else if (cc == c6cc_pkg::CC_ALU) begin
         use_tab = 1'b1;
         if (aaa == c6cc_pkg::AAA_STORE) begin
            entry = c6cc_pkg::TAB_STA[bbb];
         end else begin
            entry = c6cc_pkg::TAB_ALU[bbb];
            if (bbb == c6cc_pkg::BBB_INDY) begin
               pen = low_carry(item.pointer_lo, item.index_y);
            end else if (bbb == c6cc_pkg::BBB_ABSY) begin
               pen = low_carry(item.operand_lo, item.index_y);
            end else if (bbb == c6cc_pkg::BBB_ABSX) begin
               pen = low_carry(item.operand_lo, item.index_x);
            end
         end
      end else if (cc == c6cc_pkg::CC_RMW) begin
         use_tab = 1'b1;
         if (aaa == c6cc_pkg::AAA_STORE) begin
            entry = c6cc_pkg::TAB_STX[bbb];
         end else if (aaa == c6cc_pkg::AAA_LOAD) begin
            entry = c6cc_pkg::TAB_LDX[bbb];
            if (bbb == c6cc_pkg::BBB_ABSX) begin
               pen = low_carry(item.operand_lo, item.index_y);
            end
         end else if (aaa >= c6cc_pkg::AAA_INC) begin
            entry = c6cc_pkg::TAB_INCDEC[bbb];
         end else begin
            entry = c6cc_pkg::TAB_RMW[bbb];
         end
      end else if (cc == c6cc_pkg::CC_CTL) begin
         use_tab = 1'b1;
         if (aaa == c6cc_pkg::AAA_0) begin
            entry = 4'd2;
         end else if (aaa == c6cc_pkg::AAA_2) begin
            entry = 4'd3;
         end else if (aaa == c6cc_pkg::AAA_3) begin
            entry = 4'd5;
         end else begin
            entry = c6cc_pkg::TAB_CTL[bbb];
         end
         if (bbb == c6cc_pkg::BBB_ABSX && aaa != c6cc_pkg::AAA_STORE) begin
            pen = low_carry(item.operand_lo, item.index_x);
         end
      end else begin
         cyc = 3'd2;
      end

      // Undefined entries hold count 2 and take no penalty
      if (use_tab) begin
         cyc = entry[2:0] + {2'b00, pen & ~entry[3]};
      end

      result.cycles       = cyc;
      result.undefined_op = use_tab & entry[3];
   end

endmodule

`default_nettype wire

// ----- src/cpu6502_cycle_count_core.sv -----
// ----------------------------------------------------------------------------
// cpu6502_cycle_count_core - 6502 instruction cycle timing
// Returns the clock cycle count of one instruction per request transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one instruction context: opcode, operand word, zero-page
//   pointer word, operand address, X, Y and status flags. rsp_bus returns the
//   cycle count and an undefined-opcode flag, one response per request, in
//   request order.
//   A request is taken into the input register, decoded combinationally, and
//   its result is loaded into the response register that drives rsp_bus; a
//   stalled response holds in that register.
//   Throughput: one transaction per cycle while rsp_bus is not stalled; the
//   decoder is combinational and sits between the input and response registers.
//   Reset clears both valid flags; no response is pending afterwards.
//   When the receiver holds rsp_bus.ready low, the response register holds,
//   the input register still takes one more transaction, and req_bus.ready
//   falls only once both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu6502_cycle_count_core (
   input  wire         clock,
   input  wire         reset,
   c6cc_req_if.sink    req_bus,
   c6cc_rsp_if.source  rsp_bus
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   c6cc_pkg::item_type   in_item_ff;
   c6cc_pkg::item_type   in_item_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   c6cc_pkg::result_type out_result_ff;
   c6cc_pkg::result_type dec_result;
   logic                 out_take;
   logic                 req_fire;

   assign out_take      = ~out_valid_ff | rsp_bus.ready;
   assign req_bus.ready = ~in_valid_ff | out_take;
   assign req_fire      = req_bus.valid & req_bus.ready;

   assign in_item_in.opcode     = req_bus.opcode;
   assign in_item_in.operand_lo = req_bus.operand_word[7:0];
   assign in_item_in.pointer_lo = req_bus.pointer_word[7:0];
   assign in_item_in.pc_lo      = req_bus.operand_pc[7:0];
   assign in_item_in.index_x    = req_bus.index_x;
   assign in_item_in.index_y    = req_bus.index_y;
   assign in_item_in.status     = req_bus.status;

   assign in_valid_in  = req_fire ? 1'b1 : (out_take ? 1'b0 : in_valid_ff);
   assign out_valid_in = out_take ? in_valid_ff : 1'b1;

   c6cc_decode u_decode (
      .item   (in_item_ff),
      .result (dec_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
      // advance only when the response register is free or being taken
      if (out_take && in_valid_ff) begin
         out_result_ff <= dec_result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.cycles       = out_result_ff.cycles;
   assign rsp_bus.undefined_op = out_result_ff.undefined_op;

endmodule

`default_nettype wire

// ----- src/c6cc_checker.sv -----
// ----------------------------------------------------------------------------
// c6cc_checker - port-level checks for the cycle count core of the 6502
// Watches the request and response channels and checks timing and result
// properties of the core.
// ----------------------------------------------------------------------------
`default_nettype none

module c6cc_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_valid,
   input wire       req_ready,
   input wire [7:0] req_opcode,
   input wire [7:0] req_status,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [2:0] rsp_cycles,
   input wire       rsp_undefined_op
);

   logic req_fire;
   assign req_fire = req_valid & req_ready;

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a valid response never reports a count below two
   a_min_cycles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cycles >= 3'd2)
      else $error("cycle count below two");

   a_undef_two: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_undefined_op |-> rsp_cycles == 3'd2)
      else $error("undefined opcode without count of two");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire ##1 rsp_ready |=> rsp_valid)
      else $error("response missing two cycles after request");

   a_brk: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_opcode == c6cc_pkg::OP_BRK && !req_status[2] ##1 rsp_ready
      |=> rsp_cycles == 3'd7)
      else $error("BRK with interrupts enabled not seven cycles");

endmodule

bind cpu6502_cycle_count_core c6cc_checker u_c6cc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_opcode       (req_bus.opcode),
   .req_status       (req_bus.status),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_cycles       (rsp_bus.cycles),
   .rsp_undefined_op (rsp_bus.undefined_op)
);

`default_nettype wire

// ----- dv/cpu6502_cycle_count_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu6502_cycle_count_core_tb - cycle timing core testbench
// Drives instruction contexts into the core and checks each returned cycle
// count and undefined flag against a local timing predictor. It runs a
// directed set of corner cases, then random instructions under three idle
// mixes, with output stalls long enough to fill the core and a full drain.
// ----------------------------------------------------------------------------

module cpu6502_cycle_count_core_tb;

   localparam int  LIMIT_CYCLES = 200000;
   localparam int  HOLD_CYCLES  = 200;
   localparam int  PHASE_ITEMS  = 640;
   localparam int  SETTLE       = 8;
   localparam int  NO_TIMING    = -1;

   // Status flag bit positions
   localparam int FLAG_N = 7;
   localparam int FLAG_V = 6;
   localparam int FLAG_I = 2;
   localparam int FLAG_Z = 1;
   localparam int FLAG_C = 0;

   // Opcodes used by the directed cases
   localparam logic [7:0] OP_BPL      = 8'h10;
   localparam logic [7:0] OP_BMI      = 8'h30;
   localparam logic [7:0] OP_BCS      = 8'hB0;
   localparam logic [7:0] OP_BEQ      = 8'hF0;
   localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
   localparam logic [7:0] OP_LDA_ABSY = 8'hB9;
   localparam logic [7:0] OP_LDA_INDY = 8'hB1;
   localparam logic [7:0] OP_STA_ABSX = 8'h9D;
   localparam logic [7:0] OP_STA_INDY = 8'h91;
   localparam logic [7:0] OP_DEC_ABSX = 8'hDE;
   localparam logic [7:0] OP_LDX_ABSY = 8'hBE;
   localparam logic [7:0] OP_STA_IMM  = 8'h89;
   localparam logic [7:0] OP_RMW_INDX = 8'h02;
   localparam logic [7:0] OP_CC3_TOP  = 8'hFF;
   localparam logic [7:0] OP_NOP_ABSX = 8'h1C;
   localparam logic [7:0] OP_JMP_ABS  = 8'h4C;
   localparam logic [7:0] OP_JMP_IND  = 8'h6C;
   localparam logic [7:0] OP_TXA      = 8'h8A;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [15:0] operand_word;
      logic [15:0] pointer_word;
      logic [15:0] operand_pc;
      logic [7:0]  index_x;
      logic [7:0]  index_y;
      logic [7:0]  status;
   } instr_ctx_type;

   // Base counts per bbb, one table per opcode group
   int alu_base    [8] = '{6, 3, 2, 4, 5, 4, 4, 4};
   int sta_base    [8] = '{6, 3, NO_TIMING, 4, 6, 4, 5, 5};
   int rmw_base    [8] = '{NO_TIMING, 5, 2, 6, NO_TIMING, 6, NO_TIMING, 7};
   int stx_base    [8] = '{NO_TIMING, 3, NO_TIMING, 4, NO_TIMING, 4, NO_TIMING, NO_TIMING};
   int ldx_base    [8] = '{2, 3, NO_TIMING, 4, NO_TIMING, 4, NO_TIMING, 4};
   int incdec_base [8] = '{NO_TIMING, 5, NO_TIMING, 6, NO_TIMING, 6, NO_TIMING, 7};
   int ctl_base    [8] = '{2, 3, NO_TIMING, 4, NO_TIMING, 4, NO_TIMING, 4};

   logic clock = 1'b0;
   logic reset;

   c6cc_req_if req_bus ();
   c6cc_rsp_if rsp_bus ();

   cpu6502_cycle_count_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   c6cc_pkg::result_type timing_due[$];
   c6cc_pkg::result_type head_timing;
   int         send_idle_pct;
   int         recv_idle_pct;
   logic       rsp_hold;
   int         cycle_count = 0;
   int         mismatch_count;
   int         results_checked;
   int         instr_sent;
   int         stall_cycles;
   bit         op_seen [256];

   always #6 clock = ~clock;

   // ------------------------------------------------------------------------
   // Timing predictor
   // ------------------------------------------------------------------------
   function automatic logic page_crossed(logic [15:0] base_addr, logic [7:0] idx);
      logic [15:0] sum;
      sum = base_addr + {8'h00, idx};
      return sum[15:8] != base_addr[15:8];
   endfunction

   function automatic c6cc_pkg::result_type predict_timing(instr_ctx_type c);
      logic [7:0]  op;
      logic [2:0]  aaa;
      logic [2:0]  bbb;
      logic [1:0]  cc;
      logic        flag;
      logic        pen;
      logic        from_table;
      logic [15:0] next_pc;
      logic [15:0] target;
      int          cnt;
      int          base;
      c6cc_pkg::result_type r;
      op         = c.opcode;
      aaa        = op[7:5];
      bbb        = op[4:2];
      cc         = op[1:0];
      pen        = 1'b0;
      from_table = 1'b0;
      cnt        = 2;
      base       = 2;
      r.undefined_op = 1'b0;
      if (op == c6cc_pkg::OP_NOP_ZP0 || op == c6cc_pkg::OP_NOP_ZP1 ||
          op == c6cc_pkg::OP_NOP_ZP2) begin
         cnt = 3;
      end else if (op == c6cc_pkg::OP_NOP_ABS || op == c6cc_pkg::OP_NOP_ZPX0 ||
                   op == c6cc_pkg::OP_NOP_ZPX1 || op == c6cc_pkg::OP_NOP_ZPX2 ||
                   op == c6cc_pkg::OP_NOP_ZPX3 || op == c6cc_pkg::OP_NOP_ZPX4 ||
                   op == c6cc_pkg::OP_NOP_ZPX5) begin
         cnt = 4;
      end else if (op[4:0] == c6cc_pkg::BRANCH_PAT) begin
         case (op[7:6])
            c6cc_pkg::BR_N: flag = c.status[FLAG_N];
            c6cc_pkg::BR_V: flag = c.status[FLAG_V];
            c6cc_pkg::BR_C: flag = c.status[FLAG_C];
            default:        flag = c.status[FLAG_Z];
         endcase
         if (flag == op[5]) begin
            // taken: penalty measured from the next instruction's page
            next_pc = c.operand_pc + 16'd1;
            target  = next_pc + {{8{c.operand_word[7]}}, c.operand_word[7:0]};
            cnt     = (next_pc[15:8] != target[15:8]) ? 4 : 3;
         end
      end else if (op == c6cc_pkg::OP_BRK) begin
         cnt = c.status[FLAG_I] ? 2 : 7;
      end else if (op == c6cc_pkg::OP_JSR || op == c6cc_pkg::OP_RTI ||
                   op == c6cc_pkg::OP_RTS) begin
         cnt = 6;
      end else if (op[3:0] == c6cc_pkg::LO_STACK) begin
         if (op == c6cc_pkg::OP_PHP || op == c6cc_pkg::OP_PHA)      cnt = 3;
         else if (op == c6cc_pkg::OP_PLP || op == c6cc_pkg::OP_PLA) cnt = 4;
         else                                                       cnt = 2;
      end else if (op[3:0] == c6cc_pkg::LO_TRANSFER &&
                   op[7:4] >= c6cc_pkg::HI_TRANSFER) begin
         cnt = 2;
      end else begin
         from_table = 1'b1;
         case (cc)
            c6cc_pkg::CC_ALU: begin
               if (aaa == c6cc_pkg::AAA_STORE) begin
                  base = sta_base[bbb];
               end else begin
                  base = alu_base[bbb];
                  case (bbb)
                     c6cc_pkg::BBB_INDY:
                        pen = page_crossed(c.pointer_word, c.index_y);
                     c6cc_pkg::BBB_ABSY:
                        pen = page_crossed(c.operand_word, c.index_y);
                     c6cc_pkg::BBB_ABSX:
                        pen = page_crossed(c.operand_word, c.index_x);
                     default: ;
                  endcase
               end
            end
            c6cc_pkg::CC_RMW: begin
               if (aaa == c6cc_pkg::AAA_STORE) begin
                  base = stx_base[bbb];
               end else if (aaa == c6cc_pkg::AAA_LOAD) begin
                  base = ldx_base[bbb];
                  if (bbb == c6cc_pkg::BBB_ABSX)
                     pen = page_crossed(c.operand_word, c.index_y);
               end else if (aaa >= c6cc_pkg::AAA_INC) begin
                  base = incdec_base[bbb];
               end else begin
                  base = rmw_base[bbb];
               end
            end
            c6cc_pkg::CC_CTL: begin
               if (aaa == c6cc_pkg::AAA_0)      base = 2;
               else if (aaa == c6cc_pkg::AAA_2) base = 3;
               else if (aaa == c6cc_pkg::AAA_3) base = 5;
               else                             base = ctl_base[bbb];
               if (bbb == c6cc_pkg::BBB_ABSX && aaa != c6cc_pkg::AAA_STORE)
                  pen = page_crossed(c.operand_word, c.index_x);
            end
            default: begin
               from_table = 1'b0;
               cnt        = 2;
            end
         endcase
      end
      if (from_table) begin
         if (base == NO_TIMING) begin
            cnt            = 2;
            r.undefined_op = 1'b1;
         end else begin
            cnt = base + (pen ? 1 : 0);
         end
      end
      r.cycles = cnt[2:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic instr_ctx_type make_ctx(logic [7:0] op, logic [15:0] opw,
                                              logic [15:0] ptr, logic [15:0] pc,
                                              logic [7:0] x, logic [7:0] y,
                                              logic [7:0] st);
      instr_ctx_type c;
      c.opcode       = op;
      c.operand_word = opw;
      c.pointer_word = ptr;
      c.operand_pc   = pc;
      c.index_x      = x;
      c.index_y      = y;
      c.status       = st;
      return c;
   endfunction

   function automatic instr_ctx_type random_instr();
      instr_ctx_type c;
      c = make_ctx(8'($urandom_range(255)), 16'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
      // now and then pin the address and index fields to an extreme
      case ($urandom_range(15))
         0: begin
            c.operand_word = 16'h0000;
            c.pointer_word = 16'h0000;
            c.operand_pc   = 16'h0000;
            c.index_x      = 8'h00;
            c.index_y      = 8'h00;
         end
         1: begin
            c.operand_word = 16'hFFFF;
            c.pointer_word = 16'hFFFF;
            c.operand_pc   = 16'hFFFF;
            c.index_x      = 8'hFF;
            c.index_y      = 8'hFF;
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic send_instr(input instr_ctx_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.opcode       <= c.opcode;
      req_bus.operand_word <= c.operand_word;
      req_bus.pointer_word <= c.pointer_word;
      req_bus.operand_pc   <= c.operand_pc;
      req_bus.index_x      <= c.index_x;
      req_bus.index_y      <= c.index_y;
      req_bus.status       <= c.status;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      timing_due.push_back(predict_timing(c));
      op_seen[c.opcode] = 1'b1;
      instr_sent++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (timing_due.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // ------------------------------------------------------------------------
   // Result checker and receiver ready
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready !== 1'b1) stall_cycles++;
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (timing_due.size() == 0) begin
               report_mismatch("result transaction with no instruction pending");
            end else begin
               head_timing = timing_due.pop_front();
               if (rsp_bus.cycles !== head_timing.cycles)
                  report_mismatch($sformatf("cycles got %0d want %0d (result %0d)",
                                  rsp_bus.cycles, head_timing.cycles, results_checked));
               if (rsp_bus.undefined_op !== head_timing.undefined_op)
                  report_mismatch($sformatf("undefined_op got %b want %b (result %0d)",
                                  rsp_bus.undefined_op, head_timing.undefined_op,
                                  results_checked));
               results_checked++;
            end
         end
      end
      rsp_bus.ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("** cpu6502_cycle_count_core: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      send_idle_pct = 0;
      // BRK with interrupt disable clear and set
      send_instr(make_ctx(c6cc_pkg::OP_BRK, 16'h0000, 16'h0000, 16'h0000,
                          8'h00, 8'h00, 8'h00));
      send_instr(make_ctx(c6cc_pkg::OP_BRK, 16'h0000, 16'h0000, 16'h0000,
                          8'h00, 8'h00, 8'h04));
      // branches: not taken, taken same page, forward cross, backward cross, wrap
      send_instr(make_ctx(OP_BPL, 16'h0010, 16'h0000, 16'h1000, 8'h00, 8'h00, 8'h80));
      send_instr(make_ctx(OP_BPL, 16'h0010, 16'h0000, 16'h1000, 8'h00, 8'h00, 8'h00));
      send_instr(make_ctx(OP_BMI, 16'h007F, 16'h0000, 16'h10F0, 8'h00, 8'h00, 8'h80));
      send_instr(make_ctx(OP_BEQ, 16'h0080, 16'h0000, 16'h1000, 8'h00, 8'h00, 8'h02));
      send_instr(make_ctx(OP_BCS, 16'h00FF, 16'h0000, 16'hFFFF, 8'h00, 8'h00, 8'h01));
      // indexed reads: cross, wrap past the top, no cross, indirect cross
      send_instr(make_ctx(OP_LDA_ABSX, 16'h12F0, 16'h0000, 16'h0200, 8'h20, 8'h00, 8'h00));
      send_instr(make_ctx(OP_LDA_ABSX, 16'hFFFF, 16'h0000, 16'h0200, 8'h01, 8'h00, 8'h00));
      send_instr(make_ctx(OP_LDA_ABSY, 16'h1200, 16'h0000, 16'h0200, 8'h00, 8'hFF, 8'h00));
      send_instr(make_ctx(OP_LDA_INDY, 16'h0040, 16'h20FF, 16'h0200, 8'h00, 8'h01, 8'h00));
      // stores and read-modify-write never pay the crossing
      send_instr(make_ctx(OP_STA_ABSX, 16'h12F0, 16'h0000, 16'h0200, 8'h20, 8'h00, 8'h00));
      send_instr(make_ctx(OP_STA_INDY, 16'h0040, 16'h20FF, 16'h0200, 8'h00, 8'h01, 8'h00));
      send_instr(make_ctx(OP_DEC_ABSX, 16'h12F0, 16'h0000, 16'h0200, 8'h20, 8'h00, 8'h00));
      // LDX abs,Y pays it, indexed by Y
      send_instr(make_ctx(OP_LDX_ABSY, 16'h12F0, 16'h0000, 16'h0200, 8'h00, 8'h20, 8'h00));
      // table holes, cc = 3, the cc = 0 specials and a transfer
      send_instr(make_ctx(OP_STA_IMM, 16'h12F0, 16'h0000, 16'h0200, 8'h20, 8'h20, 8'h00));
      send_instr(make_ctx(OP_RMW_INDX, 16'h0000, 16'h0000, 16'h0200, 8'h00, 8'h00, 8'h00));
      send_instr(make_ctx(OP_CC3_TOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
      send_instr(make_ctx(OP_NOP_ABSX, 16'h12F0, 16'h0000, 16'h0200, 8'h20, 8'h00, 8'h00));
      send_instr(make_ctx(OP_JMP_ABS, 16'h1234, 16'h0000, 16'h0200, 8'hFF, 8'h00, 8'h00));
      send_instr(make_ctx(OP_JMP_IND, 16'h1234, 16'h0000, 16'h0200, 8'hFF, 8'h00, 8'h00));
      send_instr(make_ctx(c6cc_pkg::OP_NOP_ZP0, 16'h0000, 16'h0000, 16'h0200,
                          8'h00, 8'h00, 8'h00));
      send_instr(make_ctx(c6cc_pkg::OP_NOP_ABS, 16'h0000, 16'h0000, 16'h0200,
                          8'h00, 8'h00, 8'h00));
      send_instr(make_ctx(c6cc_pkg::OP_JSR, 16'h0000, 16'h0000, 16'h0200,
                          8'h00, 8'h00, 8'h00));
      send_instr(make_ctx(c6cc_pkg::OP_PLA, 16'h0000, 16'h0000, 16'h0200,
                          8'h00, 8'h00, 8'h00));
      send_instr(make_ctx(OP_TXA, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
   endtask

   task automatic test_random(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_instr(random_instr());
   endtask

   // Hold the response side long enough that the core fills and stalls input
   task automatic test_backpressure();
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      send_idle_pct = 0;
      repeat (40) send_instr(random_instr());
   endtask

   // Pause the sender until every result is back, then resume
   task automatic test_drain_pause();
      send_idle_pct = 10;
      repeat (20) send_instr(random_instr());
      drain_results();
      repeat (20) send_instr(random_instr());
   endtask

   initial begin
      reset                <= 1'b1;
      rsp_hold             <= 1'b0;
      req_bus.valid        <= 1'b0;
      req_bus.opcode       <= 8'h00;
      req_bus.operand_word <= 16'h0000;
      req_bus.pointer_word <= 16'h0000;
      req_bus.operand_pc   <= 16'h0000;
      req_bus.index_x      <= 8'h00;
      req_bus.index_y      <= 8'h00;
      req_bus.status       <= 8'h00;
      mismatch_count  = 0;
      results_checked = 0;
      instr_sent      = 0;
      stall_cycles    = 0;
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      recv_idle_pct = 30;
      test_directed();
      test_random(PHASE_ITEMS, 33, 65);
      test_backpressure();
      test_random(PHASE_ITEMS, 65, 33);
      test_drain_pause();
      test_random(PHASE_ITEMS, 0, 0);
      test_backpressure();

      drain_results();
      repeat (SETTLE) @(posedge clock);
      $display("Ran %0d instructions over %0d distinct opcodes; %0d results checked.",
               instr_sent, op_seen.sum() with (int'(item)), results_checked);
      $display("Input stalled %0d cycles behind a full core; %0d mismatches.",
               stall_cycles, mismatch_count);
      if (mismatch_count == 0) begin
         $display("** cpu6502_cycle_count_core: PASSED **");
      end else begin
         $display("** cpu6502_cycle_count_core: FAILED **");
      end
      $finish;
   end

endmodule
